/* hdl/sdr_pkg.sv */
package sdr_pkg;

  localparam int IN_COORD_W = 12;
  localparam int DEN_W      = 29;
  localparam int DENY_W     = 45;
  localparam int QUO_W      = 24;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_BASELINE = 3'd4;
  localparam logic [2:0] REG_ROI_LEFT = 3'd5;
  localparam logic [2:0] REG_ROI_TOP  = 3'd6;
  localparam logic [2:0] REG_STEP     = 3'd7;

  typedef struct packed {
    logic [11:0]        local_row;
    logic [11:0]        local_col;
    logic [7:0]         mask_value;
    logic signed [15:0] disparity;
    logic               disparity_invalid;
  } in_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [16:0]        point_z;
  } out_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic xsat;
    logic ysat;
  } side_t;

endpackage

/* hdl/sdr_div.sv */
module sdr_div
  import sdr_pkg::*;
#(
  parameter int DW = 29,
  parameter int QB = 24
) (
  input  logic               clk,
  input  logic [DW+QB-1:0]   num,
  input  logic [DW-1:0]      den,
  output logic [QB-1:0]      quo,
  output logic [DW-1:0]      rem
);

  localparam int RW = DW + QB;

  logic [RW-1:0] rem_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rin;
    logic [DW-1:0] din;
    logic [QB-1:0] qin;
    logic [RW-1:0] dsh;
    logic          take;
    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign qin = quo_r[k-1];
    end
    assign dsh  = RW'(din) << (QB - 1 - k);
    assign take = (rin >= dsh);
    always_ff @(posedge clk) begin
      rem_r[k] <= take ? (rin - dsh) : rin;
      den_r[k] <= din;
      quo_r[k] <= {qin[QB-2:0], take};
    end
  end

  assign quo = quo_r[QB-1];
  assign rem = rem_r[QB-1][DW-1:0];

endmodule

/* hdl/stereo_disparity_reprojection.sv */
// Throughput: one pixel per cycle; busy is never raised.
// Depth, X, Y and the stride remainders come from 24-stage restoring dividers.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
// The receiver cannot stall; each result is shown for one cycle.
module stereo_disparity_reprojection
  import sdr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int CB  = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int GW  = CB + 1;
  localparam int DXW = ((GW + 4 > 16) ? GW + 4 : 16) + 1;
  localparam int AW  = DXW - 1;
  localparam int NXW = AW + 29;
  localparam int NYW = AW + 45;
  localparam int CXW = (NXW > DEN_W + QUO_W) ? NXW : DEN_W + QUO_W;
  localparam int CYW = (NYW > DENY_W + QUO_W) ? NYW : DENY_W + QUO_W;
  localparam int SW  = 8 + QUO_W;

  logic [15:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [19:0] base_r;
  logic [11:0] roi_left_r, roi_top_r;
  logic [7:0]  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 16'd16384;
      focal_y_r  <= 16'd16384;
      center_x_r <= '0;
      center_y_r <= '0;
      base_r     <= 20'd100000;
      roi_left_r <= '0;
      roi_top_r  <= '0;
      step_r     <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x_r  <= cfg_data[15:0];
        REG_FOCAL_Y:  focal_y_r  <= cfg_data[15:0];
        REG_CENTER_X: center_x_r <= cfg_data[15:0];
        REG_CENTER_Y: center_y_r <= cfg_data[15:0];
        REG_BASELINE: base_r     <= cfg_data;
        REG_ROI_LEFT: roi_left_r <= cfg_data[11:0];
        REG_ROI_TOP:  roi_top_r  <= cfg_data[11:0];
        REG_STEP:     step_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: input register and early rejects
  logic          v0_r;
  logic [CB-1:0] lrow0_r, lcol0_r;
  logic [GW-1:0] grow0_r, gcol0_r;
  logic [14:0]   d0_r;
  logic          keep0;

  assign keep0 = (in_data.mask_value != 8'd0) && !in_data.disparity_invalid &&
                 (in_data.disparity != 16'sd0) && !in_data.disparity[15];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start && keep0;
    lrow0_r <= in_data.local_row[CB-1:0];
    lcol0_r <= in_data.local_col[CB-1:0];
    grow0_r <= GW'(in_data.local_row[CB-1:0]) + GW'(roi_top_r[CB-1:0]);
    gcol0_r <= GW'(in_data.local_col[CB-1:0]) + GW'(roi_left_r[CB-1:0]);
    d0_r    <= in_data.disparity[14:0];
  end

  // stage 1: focal*baseline, denominator, centered offsets
  logic              v1_r;
  logic [35:0]       fb1_r;
  logic [DEN_W-1:0]  den1_r;
  logic [AW-1:0]     ax1_r, ay1_r;
  logic              xn1_r, yn1_r;
  logic [CB-1:0]     lrow1_r, lcol1_r;
  logic signed [DXW-1:0] dx, dy;

  assign dx = $signed(DXW'({gcol0_r, 4'b0000})) - $signed(DXW'(center_x_r));
  assign dy = $signed(DXW'({grow0_r, 4'b0000})) - $signed(DXW'(center_y_r));

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
    fb1_r   <= 36'(focal_x_r) * 36'(base_r);
    den1_r  <= DEN_W'(d0_r) * DEN_W'(15625);
    xn1_r   <= dx[DXW-1];
    yn1_r   <= dy[DXW-1];
    ax1_r   <= dx[DXW-1] ? AW'(-dx) : AW'(dx);
    ay1_r   <= dy[DXW-1] ? AW'(-dy) : AW'(dy);
    lrow1_r <= lrow0_r;
    lcol1_r <= lcol0_r;
  end

  // stage 2: depth window, offset*baseline, Y denominator
  logic              v2_r;
  logic [AW+19:0]    axb2_r, ayb2_r;
  logic [DENY_W-1:0] dyd2_r;
  logic [35:0]       fb2_r;
  logic [DEN_W-1:0]  den2_r;
  logic              xn2_r, yn2_r;
  logic [CB-1:0]     lrow2_r, lcol2_r;
  logic              win;
  logic [15:0]       fy1;

  assign win = ((39'(fb1_r) * 39'd5) > (39'(den1_r) << 1)) &&
               (39'(fb1_r) <= (39'(den1_r) * 39'd400));
  assign fy1 = (focal_y_r == 16'd0) ? 16'd1 : focal_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r && win;
    axb2_r  <= (AW+20)'(ax1_r) * (AW+20)'(base_r);
    ayb2_r  <= (AW+20)'(ay1_r) * (AW+20)'(base_r);
    dyd2_r  <= DENY_W'(den1_r) * DENY_W'(fy1);
    fb2_r   <= fb1_r;
    den2_r  <= den1_r;
    xn2_r   <= xn1_r;
    yn2_r   <= yn1_r;
    lrow2_r <= lrow1_r;
    lcol2_r <= lcol1_r;
  end

  // stage 3: Y numerator product
  logic              v3_r;
  logic [AW+35:0]    ayf3_r;
  logic [AW+19:0]    axb3_r;
  logic [DENY_W-1:0] dyd3_r;
  logic [35:0]       fb3_r;
  logic [DEN_W-1:0]  den3_r;
  logic              xn3_r, yn3_r;
  logic [CB-1:0]     lrow3_r, lcol3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    ayf3_r  <= (AW+36)'(ayb2_r) * (AW+36)'(focal_x_r);
    axb3_r  <= axb2_r;
    dyd3_r  <= dyd2_r;
    fb3_r   <= fb2_r;
    den3_r  <= den2_r;
    xn3_r   <= xn2_r;
    yn3_r   <= yn2_r;
    lrow3_r <= lrow2_r;
    lcol3_r <= lcol2_r;
  end

  // stage 4: rounded numerators
  logic              v4_r;
  logic [44:0]       nz4_r;
  logic [NXW-1:0]    nx4_r;
  logic [NYW-1:0]    ny4_r;
  logic [DENY_W-1:0] dyd4_r;
  logic [DEN_W-1:0]  den4_r;
  logic              xn4_r, yn4_r;
  logic [CB-1:0]     lrow4_r, lcol4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    nz4_r   <= {1'b0, fb3_r, 8'h00} + 45'(den3_r >> 1);
    nx4_r   <= {1'b0, axb3_r, 8'h00} + NXW'(den3_r >> 1);
    ny4_r   <= {1'b0, ayf3_r, 8'h00} + NYW'(dyd3_r >> 1);
    dyd4_r  <= dyd3_r;
    den4_r  <= den3_r;
    xn4_r   <= xn3_r;
    yn4_r   <= yn3_r;
    lrow4_r <= lrow3_r;
    lcol4_r <= lcol3_r;
  end

  // stage 5: overflow checks, divider operands
  logic                     v5_r;
  logic [DEN_W+QUO_W-1:0]   nz5_r, nx5_r;
  logic [DENY_W+QUO_W-1:0]  ny5_r;
  logic [DENY_W-1:0]        dyd5_r;
  logic [DEN_W-1:0]         den5_r;
  logic [SW-1:0]            nr5_r, nc5_r;
  side_t                    side5_r;
  logic                     xsat, ysat;
  logic [7:0]               step_eff;

  assign xsat = CXW'(nx4_r) >= (CXW'(den4_r) << QUO_W);
  assign ysat = CYW'(ny4_r) >= (CYW'(dyd4_r) << QUO_W);
  assign step_eff = (step_r == 8'd0) ? 8'd1 : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    nz5_r   <= (DEN_W+QUO_W)'(nz4_r);
    nx5_r   <= xsat ? '0 : (DEN_W+QUO_W)'(nx4_r);
    ny5_r   <= ysat ? '0 : (DENY_W+QUO_W)'(ny4_r);
    dyd5_r  <= dyd4_r;
    den5_r  <= den4_r;
    nr5_r   <= SW'(lrow4_r);
    nc5_r   <= SW'(lcol4_r);
    side5_r <= '{xneg: xn4_r, yneg: yn4_r, xsat: xsat, ysat: ysat};
  end

  logic [QUO_W-1:0]  qz, qx, qy, qr_unused, qc_unused;
  logic [DEN_W-1:0]  rz_unused, rx_unused;
  logic [DENY_W-1:0] ry_unused;
  logic [7:0]        rem_row, rem_col;

  sdr_div #(.DW(DEN_W),  .QB(QUO_W)) u_div_z (
    .clk(clk), .num(nz5_r), .den(den5_r), .quo(qz), .rem(rz_unused));
  sdr_div #(.DW(DEN_W),  .QB(QUO_W)) u_div_x (
    .clk(clk), .num(nx5_r), .den(den5_r), .quo(qx), .rem(rx_unused));
  sdr_div #(.DW(DENY_W), .QB(QUO_W)) u_div_y (
    .clk(clk), .num(ny5_r), .den(dyd5_r), .quo(qy), .rem(ry_unused));
  sdr_div #(.DW(8),      .QB(QUO_W)) u_mod_r (
    .clk(clk), .num(nr5_r), .den(step_eff), .quo(qr_unused), .rem(rem_row));
  sdr_div #(.DW(8),      .QB(QUO_W)) u_mod_c (
    .clk(clk), .num(nc5_r), .den(step_eff), .quo(qc_unused), .rem(rem_col));

  logic [QUO_W-1:0] vd_r;
  side_t            sd_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else vd_r <= {vd_r[QUO_W-2:0], v5_r};
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= side5_r;
    for (int i = 1; i < QUO_W; i++) sd_r[i] <= sd_r[i-1];
  end

  // output: sign, saturation, stride gate
  side_t       sd;
  logic [23:0] px, py;
  logic        out_valid_r;
  out_t        out_data_r;

  assign sd = sd_r[QUO_W-1];

  always_comb begin
    if (!sd.xneg) px = (sd.xsat || qx > 24'h7FFFFF) ? 24'h7FFFFF : qx;
    else px = (sd.xsat || qx > 24'h800000) ? 24'h800000 : (24'h0 - qx);
    if (!sd.yneg) py = (sd.ysat || qy > 24'h7FFFFF) ? 24'h7FFFFF : qy;
    else py = (sd.ysat || qy > 24'h800000) ? 24'h800000 : (24'h0 - qy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vd_r[QUO_W-1] && (rem_row == 8'd0) && (rem_col == 8'd0);
    out_data_r.point_x <= $signed(px);
    out_data_r.point_y <= $signed(py);
    out_data_r.point_z <= qz[16:0];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* test/stereo_disparity_reprojection_test.sv */
`timescale 1ns / 100ps

module stereo_disparity_reprojection_test;
  import sdr_pkg::*;

  localparam int LATENCY = 30;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;

  stereo_disparity_reprojection i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // camera settings mirrored for prediction
  logic [15:0] fx, fy, cx, cy;
  logic [19:0] base;
  logic [11:0] roi_l, roi_t;
  logic [7:0] stride;

  out_t points_q[$];
  int errors;
  int beats_in;
  int points_seen;
  int dropped;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("stereo_disparity_reprojection verification failed");
      $finish;
    end
  end

  function automatic logic [23:0] clamp_xy(bit neg, longint unsigned mag);
    if (!neg) return (mag > 64'h7FFFFF) ? 24'h7FFFFF : mag[23:0];
    if (mag > 64'h800000) mag = 64'h800000;
    return 24'(-mag);
  endfunction

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic bit reproject(in_t px, output out_t pt);
    longint unsigned d, fb, den, z, ax, ay, xm, ym, fyv;
    longint col, row, dx, dy;
    int unsigned st;
    st = (stride == 0) ? 1 : stride;
    pt = '0;
    if ((px.local_row % st) != 0 || (px.local_col % st) != 0) return 0;
    if (px.mask_value == 0) return 0;
    if (px.disparity_invalid || px.disparity <= 0) return 0;
    d = px.disparity;
    fb = longint'(fx) * base;
    if (!(fb * 160 > 64'd1000000 * d)) return 0;
    if (fb * 16 > 64'd100000000 * d) return 0;
    den = 64'd15625 * d;
    z = round_div(fb * 256, den);
    col = longint'(px.local_col) + roi_l;
    row = longint'(px.local_row) + roi_t;
    dx = 16 * col - longint'(cx);
    dy = 16 * row - longint'(cy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    xm = round_div(ax * base * 256, den);
    fyv = (fy == 0) ? 1 : fy;
    ym = round_div(ay * fb * 256, den * fyv);
    pt.point_x = clamp_xy(dx < 0 && xm != 0, xm);
    pt.point_y = clamp_xy(dy < 0 && ym != 0, ym);
    pt.point_z = z[16:0];
    return 1;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      points_seen++;
      if (points_q.size() == 0) begin
        errors++;
        $display("%0t unexpected point %h", $time, out_data);
      end else begin
        want = points_q.pop_front();
        if (out_data.point_x !== want.point_x || out_data.point_y !== want.point_y ||
            out_data.point_z !== want.point_z) begin
          errors++;
          $display("%0t point mismatch expected %h actual %h", $time, want, out_data);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 20'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCAL_X:  fx = 16'(val);
      REG_FOCAL_Y:  fy = 16'(val);
      REG_CENTER_X: cx = 16'(val);
      REG_CENTER_Y: cy = 16'(val);
      REG_BASELINE: base = 20'(val);
      REG_ROI_LEFT: roi_l = 12'(val);
      REG_ROI_TOP:  roi_t = 12'(val);
      REG_STEP:     stride = 8'(val);
      default: ;
    endcase
  endtask

  task automatic drain;
    while (points_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic gap;
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                     : $urandom_range(0, 2);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // beat with optional hand-typed point; has_want=0 uses predictor
  task automatic send(in_t px, bit has_want, bit keep, out_t want);
    out_t pt;
    bit hit;
    start <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    hit = reproject(px, pt);
    if (has_want) begin
      if (hit !== keep || (keep && pt !== want)) begin
        errors++;
        $display("%0t table row expected %b %h predicted %b %h", $time, keep, want, hit, pt);
      end
    end
    if (hit) points_q = {points_q, pt};
    else dropped++;
    beats_in++;
  endtask

  function automatic in_t pixel(int r, int c, int m, int d, bit inv);
    in_t p;
    p.local_row = 12'(r);
    p.local_col = 12'(c);
    p.mask_value = 8'(m);
    p.disparity = 16'(d);
    p.disparity_invalid = inv;
    return p;
  endfunction

  function automatic in_t rand_pixel(bit on_grid);
    in_t p;
    int st;
    st = (stride == 0) ? 1 : stride;
    p = in_t'({$urandom, $urandom});
    if (on_grid) begin
      p.local_row = 12'(st * $urandom_range(0, 4095 / st));
      p.local_col = 12'(st * $urandom_range(0, 4095 / st));
      if ($urandom_range(0, 7) != 0) p.mask_value[0] = 1'b1;
      p.disparity_invalid = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 3))
        0: p.disparity = 16'($urandom_range(1, 32767));
        1: p.disparity = 16'($urandom_range(1, 2047));
        2: p.disparity = 16'($urandom_range(1, 255));
        default: p.disparity = 16'($urandom);
      endcase
    end
    return p;
  endfunction

  typedef struct {
    in_t px;
    bit has_want;
    bit keep;
    out_t want;
  } row_t;

  // sweep settings; phase % 4 == 0 picks random values
  task automatic pick_settings(int phase);
    case (phase % 4)
      0: begin
        write_reg(REG_FOCAL_X, $urandom_range(16, 65535));
        write_reg(REG_FOCAL_Y, $urandom_range(0, 65535));
        write_reg(REG_CENTER_X, $urandom_range(0, 65535));
        write_reg(REG_CENTER_Y, $urandom_range(0, 65535));
        write_reg(REG_BASELINE, $urandom_range(1, 1000000));
        write_reg(REG_ROI_LEFT, $urandom_range(0, 4095));
        write_reg(REG_ROI_TOP, $urandom_range(0, 4095));
        write_reg(REG_STEP, $urandom_range(0, 8));
      end
      1: begin
        write_reg(REG_FOCAL_X, 16'hFFFF);
        write_reg(REG_FOCAL_Y, 16);
        write_reg(REG_CENTER_X, 0);
        write_reg(REG_CENTER_Y, 16'hFFFF);
        write_reg(REG_BASELINE, 1000000);
        write_reg(REG_ROI_LEFT, 4095);
        write_reg(REG_ROI_TOP, 0);
        write_reg(REG_STEP, 1);
      end
      2: begin
        write_reg(REG_FOCAL_X, 16);
        write_reg(REG_FOCAL_Y, 0);
        write_reg(REG_CENTER_X, 16'hFFFF);
        write_reg(REG_CENTER_Y, 0);
        write_reg(REG_BASELINE, $urandom_range(1, 2));
        write_reg(REG_ROI_LEFT, 0);
        write_reg(REG_ROI_TOP, 4095);
        write_reg(REG_STEP, 255);
      end
      default: begin
        write_reg(REG_FOCAL_X, $urandom_range(8000, 40000));
        write_reg(REG_FOCAL_Y, $urandom_range(8000, 40000));
        write_reg(REG_CENTER_X, $urandom_range(0, 65535));
        write_reg(REG_CENTER_Y, $urandom_range(0, 65535));
        write_reg(REG_BASELINE, $urandom_range(50000, 600000));
        write_reg(REG_ROI_LEFT, $urandom_range(0, 4095));
        write_reg(REG_ROI_TOP, $urandom_range(0, 4095));
        write_reg(REG_STEP, $urandom_range(2, 4));
      end
    endcase
  endtask

  initial begin
    row_t table_rows[$];
    row_t r;
    out_t none;
    none = '0;
    errors = 0;
    beats_in = 0;
    points_seen = 0;
    dropped = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FOCAL_X;
    cfg_data = '0;
    fx = 16'd16384; fy = 16'd16384; cx = 16'd0; cy = 16'd0;
    base = 20'd100000; roi_l = 12'd0; roi_t = 12'd0; stride = 8'd2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: F*B = 1.6384e9, d=256 (1 px) -> z = 1.6384e9*256/(15625*256) = 104857.6 too deep
    // d=4096 (16 px): z = 6553.6 -> 6554; x at col 0 -> 0
    r.px = pixel(0, 0, 1, 4096, 0); r.has_want = 1; r.keep = 1;
    r.want = '{point_x: 0, point_y: 0, point_z: 6554}; table_rows = {table_rows, r};
    r.px = pixel(1, 0, 255, 4096, 0); r.has_want = 1; r.keep = 0; r.want = none;
    table_rows = {table_rows, r};
    r.px = pixel(0, 3, 255, 4096, 0); table_rows = {table_rows, r};
    r.px = pixel(0, 0, 0, 4096, 0); table_rows = {table_rows, r};
    r.px = pixel(0, 0, 9, 4096, 1); table_rows = {table_rows, r};
    r.px = pixel(0, 0, 9, 0, 0); table_rows = {table_rows, r};
    r.px = pixel(0, 0, 9, -1, 0); table_rows = {table_rows, r};
    r.px = pixel(0, 0, 9, -32768, 0); table_rows = {table_rows, r};
    r.px = pixel(0, 0, 9, 256, 0); table_rows = {table_rows, r};
    r.has_want = 0;
    r.px = pixel(4094, 4094, 128, 32767, 0); table_rows = {table_rows, r};
    r.px = pixel(4094, 0, 1, 4195, 0); table_rows = {table_rows, r};
    r.px = pixel(0, 4094, 1, 4194, 0); table_rows = {table_rows, r};
    r.px = pixel(2, 2, 1, 4195, 0); table_rows = {table_rows, r};
    r.px = pixel(4095, 4095, 255, 1000, 0); table_rows = {table_rows, r};
    r.px = pixel(2048, 1024, 2, 16383, 0); table_rows = {table_rows, r};
    r.px = pixel(100, 200, 170, 8192, 0); table_rows = {table_rows, r};
    foreach (table_rows[i]) begin
      send(table_rows[i].px, table_rows[i].has_want, table_rows[i].keep, table_rows[i].want);
      if ($urandom_range(0, 2) == 0) gap();
    end
    start <= 1'b0;
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      pick_settings(phase);
      for (int n = 0; n < 125; n++) begin
        send(rand_pixel($urandom_range(0, 9) != 0), 0, 0, none);
        if (n % 40 < 20) gap();
      end
      start <= 1'b0;
      drain();
    end

    $display("%0d pixels sent, %0d points checked, %0d dropped by stride/mask/depth tests",
             beats_in, points_seen, dropped);
    if (errors == 0 && points_q.size() == 0) begin
      $display("stereo_disparity_reprojection verification clean");
    end else begin
      $display("%0d errors, %0d points missing", errors, points_q.size());
      $display("stereo_disparity_reprojection verification failed");
    end
    $finish;
  end

endmodule
